// ===== design/dac_pkg.sv =====
`timescale 1ns / 1ps
// dac_pkg: shared types and constants for the dynamic array with compaction.
// Used by dac_store, dac_ctrl and dynamic_array_with_compaction.
package dac_pkg;

  localparam int DEPTH_DEF         = 256;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int MIN_CAPACITY_DEF  = 4;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_SET    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TAKE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== design/dac_store.sv =====
`timescale 1ns / 1ps
// dac_store: element memory, one write port and one registered read port.
// Depends on dac_pkg for the port control struct.
module dac_store #(
  parameter int DEPTH = dac_pkg::DEPTH_DEF,
  parameter int WIDTH = dac_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  dac_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import dac_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dac_ctrl.sv =====
`timescale 1ns / 1ps
// dac_ctrl: sequencer for append/get/set/remove, count and capacity policy,
// and the entry-by-entry compaction walk. Depends on dac_pkg.
module dac_ctrl #(
  parameter int DEPTH         = dac_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = dac_pkg::ELEMENT_WIDTH_DEF,
  parameter int MIN_CAPACITY  = dac_pkg::MIN_CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [dac_pkg::OPCODE_W-1:0]     opcode,
  input  logic [dac_pkg::INDEX_W-1:0]      index,
  input  logic [dac_pkg::VALUE_W-1:0]      value,
  input  logic                             res_free,
  output logic                             res_valid,
  output logic [dac_pkg::VALUE_W-1:0]      res_data,
  output logic                             res_error,
  output logic [dac_pkg::SIZE_W-1:0]       res_count,
  output logic [dac_pkg::SIZE_W-1:0]       res_capacity,
  output dac_pkg::mem_ctl_t                mem_ctl,
  output logic [$clog2(DEPTH)-1:0]         mem_waddr,
  output logic [ELEMENT_WIDTH-1:0]         mem_wdata,
  output logic [$clog2(DEPTH)-1:0]         mem_raddr,
  input  logic [ELEMENT_WIDTH-1:0]         mem_rdata
);
  import dac_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CMAX = (DEPTH > MIN_CAPACITY) ? DEPTH : MIN_CAPACITY;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int XW   = (CW > INDEX_W) ? CW : INDEX_W;

  state_t state, state_next;

  op_t                    op;
  logic [AW-1:0]          idx;
  logic [ELEMENT_WIDTH-1:0] val;
  logic [AW-1:0]          ptr;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cap;
  logic [VALUE_W-1:0]     dat;
  logic                   err;

  logic                   accept;
  op_t                    op_in;
  logic [XW-1:0]          idx_x;
  logic                   idx_bad;
  logic                   full;
  logic [AW-1:0]          ptr_inc;
  logic                   more;
  logic [CW+1:0]          cap_x;
  logic [CW+1:0]          grow3;
  logic [CW+1:0]          grow;
  logic [CW-1:0]          cnt_dec;
  logic [CW-1:0]          cap_half;
  logic                   shrink;

  assign accept  = req_valid && !req_stall;
  assign op_in   = op_t'(opcode);
  assign idx_x   = XW'(index);
  assign idx_bad = idx_x >= XW'(cnt);
  assign full    = cnt == CW'(DEPTH);
  assign ptr_inc = ptr + AW'(1);
  assign more    = (CW'(ptr) + CW'(1)) < cnt;

  // growth by 1.5, at least by one, saturated at DEPTH
  always_comb begin
    cap_x = (CW+2)'(cap);
    grow3 = (cap_x + (cap_x << 1)) >> 1;
    grow  = (grow3 <= cap_x) ? cap_x + (CW+2)'(1) : grow3;
    if (grow > (CW+2)'(DEPTH)) begin
      grow = (CW+2)'(DEPTH);
    end
  end

  assign cnt_dec  = cnt - CW'(1);
  assign cap_half = cap >> 1;
  assign shrink   = (((CW+2)'(cnt_dec) << 2) < (CW+2)'(cap)) &&
                    (cap_half >= CW'(MIN_CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    res_valid  = 1'b0;
    mem_ctl    = '0;
    mem_waddr  = idx;
    mem_wdata  = val;
    mem_raddr  = idx;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = ELEMENT_WIDTH'(value);
        if (req_valid) begin
          if (op_in == OP_APPEND) begin
            mem_ctl.we = !full;
            state_next = ST_DONE;
          end else begin
            state_next = idx_bad ? ST_DONE : ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_ctl.re = 1'b1;
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        mem_ctl.we = op == OP_SET;
        state_next = (op == OP_REMOVE) ? ST_SHIFT_RD : ST_DONE;
      end
      ST_SHIFT_RD: begin
        mem_raddr  = ptr_inc;
        mem_ctl.re = more;
        state_next = more ? ST_SHIFT_WR : ST_DONE;
      end
      ST_SHIFT_WR: begin
        mem_waddr  = ptr;
        mem_wdata  = mem_rdata;
        mem_ctl.we = 1'b1;
        state_next = ST_SHIFT_RD;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cap <= CW'(MIN_CAPACITY);
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && op_in == OP_APPEND && !full) begin
            cnt <= cnt + CW'(1);
            if (cnt >= cap) begin
              cap <= CW'(grow);
            end
          end
        end
        ST_SHIFT_RD: begin
          if (!more) begin
            cnt <= cnt_dec;
            if (shrink) begin
              cap <= cap_half;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // beat payload and walk pointer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op  <= op_in;
          idx <= idx_x[AW-1:0];
          val <= ELEMENT_WIDTH'(value);
          dat <= '0;
          err <= (op_in == OP_APPEND) ? full : idx_bad;
        end
      end
      ST_TAKE: begin
        dat <= VALUE_W'(mem_rdata);
        ptr <= idx;
      end
      ST_SHIFT_WR: begin
        ptr <= ptr_inc;
      end
      default: ;
    endcase
  end

  assign res_data     = dat;
  assign res_error    = err;
  assign res_count    = SIZE_W'(cnt);
  assign res_capacity = SIZE_W'(cap);

endmodule

// ===== design/dynamic_array_with_compaction.sv =====
`timescale 1ns / 1ps
// dynamic_array_with_compaction: indexed element store with live count and
// tracked capacity. Depends on dac_pkg, dac_ctrl and dac_store.
//
// Usage:
//   Request channel req_valid/req_stall carries opcode, index and value;
//   a beat is taken when req_valid is high and req_stall low. Response
//   channel rsp_valid/rsp_stall returns data, error, count and capacity,
//   one response beat per request beat, in order.
//   Ops: append, get, set (returns old word), remove (returns removed word,
//   then later entries move down one place).
//   An append, or any error, goes from the request straight to the response;
//   get and set first read the word (states READ, TAKE); remove then
//   walks the later entries down (SHIFT_RD, SHIFT_WR per entry).
//   The remove walk moves one entry at a time through the single
//   memory port pair (read one, write back). req_stall stays high while
//   an item is in flight, so one item is processed at a time.
//   A response waits in the output register while rsp_stall is high; the
//   next request can still be taken and finishes up to its result, which
//   is held until the register frees.
//   Reset (rst, synchronous): count 0, capacity MIN_CAPACITY; memory
//   contents are not cleared and need no clearing pass.
module dynamic_array_with_compaction #(
  parameter int DEPTH         = dac_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = dac_pkg::ELEMENT_WIDTH_DEF,
  parameter int MIN_CAPACITY  = dac_pkg::MIN_CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [dac_pkg::OPCODE_W-1:0] opcode,
  input  logic [dac_pkg::INDEX_W-1:0]  index,
  input  logic [dac_pkg::VALUE_W-1:0]  value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [dac_pkg::VALUE_W-1:0]  data,
  output logic                         error,
  output logic [dac_pkg::SIZE_W-1:0]   count,
  output logic [dac_pkg::SIZE_W-1:0]   capacity
);
  import dac_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                     res_free;
  logic                     res_valid;
  logic [VALUE_W-1:0]       res_data;
  logic                     res_error;
  logic [SIZE_W-1:0]        res_count;
  logic [SIZE_W-1:0]        res_capacity;
  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  dac_ctrl #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .MIN_CAPACITY  (MIN_CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .index        (index),
    .value        (value),
    .res_free     (res_free),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_error    (res_error),
    .res_count    (res_count),
    .res_capacity (res_capacity),
    .mem_ctl      (mem_ctl),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  dac_store #(
    .DEPTH (DEPTH),
    .WIDTH (ELEMENT_WIDTH)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_free) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      data     <= res_data;
      error    <= res_error;
      count    <= res_count;
      capacity <= res_capacity;
    end
  end

endmodule

// ===== tb/dac_check_pkg.sv =====
`timescale 1ns / 1ps
// dac_check_pkg: response checker for the dynamic array with compaction.
// Mirrors element store, count and capacity; depends on dac_pkg.
package dac_check_pkg;
  import dac_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] data;
    logic               error;
    logic [SIZE_W-1:0]  count;
    logic [SIZE_W-1:0]  capacity;
  } array_rsp_t;

  class array_checker;
    logic [VALUE_W-1:0] words [DEPTH_DEF];
    int n_held;
    int cap;
    array_rsp_t pending_rsps[$];
    int n_requests;
    int n_responses;
    int n_err_rsps;
    int peak_held;
    int cap_lo;
    int cap_hi;
    int mismatches;

    function new();
      n_held      = 0;
      cap         = MIN_CAPACITY_DEF;
      n_requests  = 0;
      n_responses = 0;
      n_err_rsps  = 0;
      peak_held   = 0;
      cap_lo      = cap;
      cap_hi      = cap;
      mismatches  = 0;
    endfunction

    function void note_request(op_t op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
      array_rsp_t want;
      int slot;
      int grown;
      want.data  = '0;
      want.error = 1'b0;
      slot = int'(idx);
      if (op == OP_APPEND) begin
        if (n_held >= DEPTH_DEF) begin
          want.error = 1'b1;
        end else begin
          if (n_held >= cap) begin
            grown = (3 * cap) >> 1;
            if (grown <= cap) grown = cap + 1;
            if (grown > DEPTH_DEF) grown = DEPTH_DEF;
            cap = grown;
          end
          words[n_held] = val;
          n_held++;
        end
      end else if (slot >= n_held) begin
        want.error = 1'b1;
      end else begin
        want.data = words[slot];
        if (op == OP_SET) begin
          words[slot] = val;
        end else if (op == OP_REMOVE) begin
          for (int i = slot; i + 1 < n_held; i++) words[i] = words[i + 1];
          n_held--;
          if (4 * n_held < cap && (cap >> 1) >= MIN_CAPACITY_DEF) cap = cap >> 1;
        end
      end
      want.count    = n_held[SIZE_W-1:0];
      want.capacity = cap[SIZE_W-1:0];
      n_requests++;
      if (want.error) n_err_rsps++;
      if (n_held > peak_held) peak_held = n_held;
      if (cap < cap_lo) cap_lo = cap;
      if (cap > cap_hi) cap_hi = cap;
      pending_rsps.push_back(want);
    endfunction

    function void check_response(logic [VALUE_W-1:0] d, logic e, logic [SIZE_W-1:0] c,
                                 logic [SIZE_W-1:0] k);
      array_rsp_t want;
      n_responses++;
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response beat: data=%h error=%b count=%0d capacity=%0d",
                   d, e, c, k);
        return;
      end
      want = pending_rsps.pop_front();
      if (want.data !== d || want.error !== e || want.count !== c || want.capacity !== k) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("response %0d mismatch: exp data=%h error=%b count=%0d capacity=%0d,",
                   n_responses, want.data, want.error, want.count, want.capacity);
          $display("  got data=%h error=%b count=%0d capacity=%0d", d, e, c, k);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: random and directed test of dynamic_array_with_compaction.
// Depends on dac_pkg, dac_check_pkg and the design sources.
module tb_top;
  import dac_pkg::*;
  import dac_check_pkg::*;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  value;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [VALUE_W-1:0]  data;
  logic                error;
  logic [SIZE_W-1:0]   count;
  logic [SIZE_W-1:0]   capacity;

  int send_idle_pct;
  int recv_stall_pct;

  array_checker sb = new();

  dynamic_array_with_compaction u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (opcode),
    .index     (index),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .data      (data),
    .error     (error),
    .count     (count),
    .capacity  (capacity)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    opcode = OP_APPEND;
    index = '0;
    value = '0;
    rsp_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  end

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(data, error, count, capacity);
  end

  task automatic send_item(op_t op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    opcode = op;
    index = idx;
    value = val;
    do @(posedge clk); while (req_stall);
    sb.note_request(op, idx, val);
  endtask

  // sender goes quiet until every response is back
  task automatic hold_off();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending_rsps.size() != 0) @(negedge clk);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int n;
    int r;
    n = sb.n_held;
    if (n < DEPTH_DEF && (n == 0 || $urandom_range(99, 0) < 12))
      return INDEX_W'($urandom_range(DEPTH_DEF - 1, n));
    r = $urandom_range(3, 0);
    if (r == 0) return '0;
    if (r == 1) return INDEX_W'(n - 1);
    return INDEX_W'($urandom_range(n - 1, 0));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_W'($urandom);
  endfunction

  task automatic random_item(int append_pct, int remove_pct);
    int r;
    op_t op;
    r = $urandom_range(99, 0);
    if (r < append_pct) op = OP_APPEND;
    else if (r < append_pct + remove_pct) op = OP_REMOVE;
    else if ($urandom_range(1, 0) == 0) op = OP_GET;
    else op = OP_SET;
    send_item(op, pick_index(), pick_value());
  endtask

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store: every access is out of range
    send_item(OP_GET, 8'd0, 32'h1111_1111);
    send_item(OP_SET, 8'd0, 32'h2222_2222);
    send_item(OP_REMOVE, 8'd0, 32'h0);
    send_item(OP_GET, 8'd255, 32'h0);
    // grow past capacity twice
    send_item(OP_APPEND, 8'd0, 32'h0000_0000);
    send_item(OP_APPEND, 8'd255, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 8'd0, 32'hA5A5_5A5A);
    send_item(OP_APPEND, 8'd0, 32'h0123_4567);
    send_item(OP_APPEND, 8'd0, 32'h89AB_CDEF);
    send_item(OP_APPEND, 8'd0, 32'hDEAD_BEEF);
    send_item(OP_APPEND, 8'd0, 32'h5555_AAAA);
    send_item(OP_GET, 8'd0, 32'h0);
    send_item(OP_GET, 8'd6, 32'h0);
    send_item(OP_GET, 8'd7, 32'h0);
    send_item(OP_SET, 8'd3, 32'hFFFF_FFFF);
    send_item(OP_SET, 8'd7, 32'h1234_5678);
    send_item(OP_REMOVE, 8'd0, 32'h0);
    send_item(OP_REMOVE, 8'd5, 32'h0);
    send_item(OP_REMOVE, 8'd2, 32'h0);
    send_item(OP_REMOVE, 8'd255, 32'h0);
    send_item(OP_GET, 8'd255, 32'h0);

    // fill to the top, then hit the full store
    while (sb.n_held < DEPTH_DEF) random_item(95, 2);
    repeat (3) send_item(OP_APPEND, pick_index(), pick_value());
    send_item(OP_GET, 8'd255, 32'h0);
    send_item(OP_SET, 8'd255, pick_value());
    hold_off();

    send_idle_pct = 79;
    repeat (100) random_item(30, 30);
    hold_off();

    send_idle_pct = 0;
    recv_stall_pct = 79;
    while (sb.n_held > 0) random_item(5, 90);
    repeat (6) random_item(30, 30);
    hold_off();

    send_idle_pct = 23;
    recv_stall_pct = 23;
    for (int i = 0; i < 150; i++) begin
      if (i == 75) hold_off();
      random_item(45, 35);
    end
    hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    sb.mismatches += sb.pending_rsps.size();
    $display("Covered %0d request beats, %0d errors, count up to %0d, capacity %0d..%0d",
             sb.n_requests, sb.n_err_rsps, sb.peak_held, sb.cap_lo, sb.cap_hi);
    $display("Response beats checked: %0d, mismatches: %0d", sb.n_responses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
